/* hw/rtl/vfsc_pkg.sv */
// Shared types and constants for the velocity friction speed cap step block.
package vfsc_pkg;

	// Register indexes on the configuration port
	localparam logic [0:0] CFG_FRICTION  = 1'b0;
	localparam logic [0:0] CFG_MAX_SPEED = 1'b1;

	localparam int REG_W   = 31;
	localparam int TICK_W  = 16;
	localparam int ACCEL_W = 32;
	localparam int VEL_W   = 32;

	// Milliseconds per second, the divisor of every dt product
	localparam int MS_PER_S = 1000;

	// Reset value of max_speed
	localparam logic [REG_W-1:0] MAX_SPEED_RST = {REG_W{1'b1}};

	// Status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

/* hw/rtl/velocity_friction_speed_cap_step.sv */
// Top level: Euler velocity step with friction and speed cap, serial datapath.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  input    | in        | s_tvalid/s_tready  | s_tdata: tick_ms, accel_x, accel_y
//  result   | out       | m_tvalid/m_tready  | m_tdata: vel_x, vel_y; m_tuser: flags
//  config   | in        | cfg_we             | cfg_addr, cfg_wdata
//
// One item is worked at a time. The bit-serial multiply-divide unit runs three to seven
// times per item (OPW = max(WORD_WIDTH,38)+1) and the serial speed unit three times.
// Reset clears velocity and control state and loads friction_coeff = 0,
// max_speed = full scale. A finished result waits in the output register; the next
// transaction is taken meanwhile, and the sequencer holds before its final load only
// while that register is still full.
module velocity_friction_speed_cap_step #(
	parameter int WORD_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        cfg_we,
	input  logic [0:0]  cfg_addr,
	input  logic [30:0] cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // [15:0] tick_ms, [47:16] accel_x, [79:48] accel_y
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] vel_x, [63:32] vel_y
	output logic [1:0]  m_tuser    // [0] stopped, [1] speed_limited
);

	localparam int W   = WORD_WIDTH;
	localparam int OPW = (W > 38 ? W : 38) + 1;
	localparam int XW  = OPW + 2;
	localparam int VW  = vfsc_pkg::VEL_W;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_FMAG = 12'b000000000010,
		ST_S0   = 12'b000000000100,
		ST_FX   = 12'b000000001000,
		ST_FY   = 12'b000000010000,
		ST_AX   = 12'b000000100000,
		ST_AY   = 12'b000001000000,
		ST_S1   = 12'b000010000000,
		ST_S2   = 12'b000100000000,
		ST_RX   = 12'b001000000000,
		ST_RY   = 12'b010000000000,
		ST_OUT  = 12'b100000000000
	} state_t;

	state_t state_q;
	logic   go_q;

	logic [vfsc_pkg::REG_W-1:0]   fric_coeff_q, max_speed_q;
	logic [vfsc_pkg::TICK_W-1:0]  tick_q;
	logic signed [vfsc_pkg::ACCEL_W-1:0] ax_q, ay_q;
	logic signed [W-1:0] vx_q, vy_q;
	logic [OPW-1:0] fmag_q, fric_q, fxm_q;
	logic [W-1:0]   s2_q;
	logic           negx_q, negy_q, stopped_q, limited_q;

	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	// serial units
	logic                 md_start, sp_start;
	logic [OPW-1:0]       md_a, md_b, md_c, md_q;
	vfsc_pkg::unit_stat_t md_stat, sp_stat;
	logic [W-1:0]         speed;

	logic [W-1:0]   mag_vx, mag_vy;
	logic [vfsc_pkg::ACCEL_W-1:0] mag_ax, mag_ay;
	logic signed [XW-1:0] vx_ext, vy_ext;

	function automatic logic signed [W-1:0] clampw(input logic signed [XW-1:0] x);
		logic signed [XW-1:0] hi, lo;
		hi = (XW'(1) <<< (W - 1)) - XW'(1);
		lo = -hi - XW'(1);
		if (x > hi) return hi[W-1:0];
		if (x < lo) return lo[W-1:0];
		return x[W-1:0];
	endfunction

	function automatic logic signed [XW-1:0] signed_term(input logic neg,
			input logic [OPW-1:0] m);
		logic signed [XW-1:0] t;
		t = XW'(signed'({1'b0, m}));
		return neg ? -t : t;
	endfunction

	always_comb begin
		mag_vx = vx_q[W-1] ? W'(-vx_q) : W'(vx_q);
		mag_vy = vy_q[W-1] ? W'(-vy_q) : W'(vy_q);
		mag_ax = ax_q[vfsc_pkg::ACCEL_W-1] ? vfsc_pkg::ACCEL_W'(-ax_q)
		                                   : vfsc_pkg::ACCEL_W'(ax_q);
		mag_ay = ay_q[vfsc_pkg::ACCEL_W-1] ? vfsc_pkg::ACCEL_W'(-ay_q)
		                                   : vfsc_pkg::ACCEL_W'(ay_q);
		vx_ext = XW'(vx_q);
		vy_ext = XW'(vy_q);
	end

	// operand select for the multiply-divide unit
	always_comb begin
		md_a = OPW'(fric_coeff_q);
		md_b = OPW'(tick_q);
		md_c = OPW'(vfsc_pkg::MS_PER_S);
		case (state_q)
			ST_FX: begin
				md_a = OPW'(mag_vx);
				md_b = fmag_q;
				md_c = OPW'(speed);
			end
			ST_FY: begin
				md_a = OPW'(mag_vy);
				md_b = fmag_q;
				md_c = OPW'(speed);
			end
			ST_AX:   md_a = OPW'(mag_ax);
			ST_AY:   md_a = OPW'(mag_ay);
			ST_RX: begin
				md_a = OPW'(mag_vx);
				md_b = OPW'(max_speed_q);
				md_c = OPW'(s2_q);
			end
			ST_RY: begin
				md_a = OPW'(mag_vy);
				md_b = OPW'(max_speed_q);
				md_c = OPW'(s2_q);
			end
			default: md_a = OPW'(fric_coeff_q);
		endcase
	end

	assign md_start = go_q && (state_q == ST_FMAG || state_q == ST_FX || state_q == ST_FY ||
	                           state_q == ST_AX || state_q == ST_AY || state_q == ST_RX ||
	                           state_q == ST_RY);
	assign sp_start = go_q && (state_q == ST_S0 || state_q == ST_S1 || state_q == ST_S2);

	vfsc_muldiv #(.OPW(OPW)) u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (md_start),
		.a     (md_a),
		.b     (md_b),
		.c     (md_c),
		.q     (md_q),
		.stat  (md_stat)
	);

	// speed is sampled while the velocity registers hold still
	vfsc_speed #(.W(W)) u_speed (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sp_start),
		.mx    (mag_vx),
		.my    (mag_vy),
		.speed (speed),
		.stat  (sp_stat)
	);

	assign s_tready = (state_q == ST_IDLE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fric_coeff_q <= '0;
			max_speed_q  <= vfsc_pkg::MAX_SPEED_RST;
		end else if (cfg_we) begin
			if (cfg_addr == vfsc_pkg::CFG_FRICTION)  fric_coeff_q <= cfg_wdata;
			if (cfg_addr == vfsc_pkg::CFG_MAX_SPEED) max_speed_q  <= cfg_wdata;
		end
	end

	// sequencer: each arithmetic step launches one serial unit, then folds its answer in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			go_q       <= 1'b0;
			vx_q       <= '0;
			vy_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// the final load sets valid itself
			if (m_tvalid_q && m_tready && state_q != ST_OUT) m_tvalid_q <= 1'b0;
			if (md_start || sp_start) go_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_FMAG;
						go_q    <= 1'b1;
					end
				end
				ST_FMAG: begin
					if (md_stat.done) begin
						fmag_q  <= md_q;
						state_q <= ST_S0;
						go_q    <= 1'b1;
					end
				end
				ST_S0: begin
					if (sp_stat.done) begin
						// friction opposes the old velocity; hold its signs
						negx_q <= !vx_q[W-1] && (vx_q != '0);
						negy_q <= !vy_q[W-1] && (vy_q != '0);
						go_q   <= 1'b1;
						if (speed == '0) begin
							fxm_q   <= '0;
							fric_q  <= '0;
							state_q <= ST_AX;
						end else begin
							fric_q  <= fmag_q;
							state_q <= ST_FX;
						end
					end
				end
				ST_FX: begin
					if (md_stat.done) begin
						fxm_q   <= md_q;
						state_q <= ST_FY;
						go_q    <= 1'b1;
					end
				end
				ST_FY: begin
					if (md_stat.done) begin
						// park y friction magnitude in fmag_q, which is spent now
						fmag_q  <= md_q;
						state_q <= ST_AX;
						go_q    <= 1'b1;
					end
				end
				ST_AX: begin
					if (md_stat.done) begin
						vx_q    <= clampw(vx_ext + XW'(clampw(signed_term(ax_q[31], md_q))));
						state_q <= ST_AY;
						go_q    <= 1'b1;
					end
				end
				ST_AY: begin
					if (md_stat.done) begin
						vy_q    <= clampw(vy_ext + XW'(clampw(signed_term(ay_q[31], md_q))));
						state_q <= ST_S1;
						go_q    <= 1'b1;
					end
				end
				ST_S1: begin
					if (sp_stat.done) begin
						if (OPW'(speed) > fric_q) begin
							vx_q      <= clampw(vx_ext + signed_term(negx_q, fxm_q));
							vy_q      <= clampw(vy_ext +
							             signed_term(negy_q, fric_q == '0 ? '0 : fmag_q));
							stopped_q <= 1'b0;
						end else begin
							vx_q      <= '0;
							vy_q      <= '0;
							stopped_q <= 1'b1;
						end
						state_q <= ST_S2;
						go_q    <= 1'b1;
					end
				end
				ST_S2: begin
					if (sp_stat.done) begin
						s2_q <= speed;
						if (OPW'(speed) > OPW'(max_speed_q)) begin
							limited_q <= 1'b1;
							state_q   <= ST_RX;
							go_q      <= 1'b1;
						end else begin
							limited_q <= 1'b0;
							state_q   <= ST_OUT;
						end
					end
				end
				ST_RX: begin
					if (md_stat.done) begin
						vx_q    <= W'(signed_term(vx_q[W-1], md_q));
						state_q <= ST_RY;
						go_q    <= 1'b1;
					end
				end
				ST_RY: begin
					if (md_stat.done) begin
						vy_q    <= W'(signed_term(vy_q[W-1], md_q));
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// load the result once the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_q <= s_tdata[15:0];
			ax_q   <= s_tdata[47:16];
			ay_q   <= s_tdata[79:48];
		end
		if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {vy_ext[VW-1:0], vx_ext[VW-1:0]};
			m_tuser_q <= {limited_q, stopped_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// a stopped body has zero speed, so it can never be rescaled
	a_stop_not_limited: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("stopped and speed_limited both set");

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == 64'd0))
		else $error("stopped result carries nonzero velocity");

	a_md_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		md_start |-> !md_stat.busy)
		else $error("multiply-divide started while busy");

	a_sp_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		sp_start |-> !sp_stat.busy)
		else $error("speed unit started while busy");

endmodule

/* hw/rtl/vfsc_muldiv.sv */
// Bit-serial floor(a * b / c): shift-add multiply, then restoring divide.
module vfsc_muldiv #(
	parameter int OPW = 39
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [OPW-1:0]      a,
	input  logic [OPW-1:0]      b,
	input  logic [OPW-1:0]      c,
	output logic [OPW-1:0]      q,
	output vfsc_pkg::unit_stat_t stat
);

	localparam int PW = 2 * OPW;
	localparam int CW = $clog2(OPW + 1);

	logic          busy_q, done_q, div_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] acc_q, ash_q;
	logic [OPW-1:0] bsh_q, rem_q, c_q;

	logic [PW-1:0] acc_n;
	logic [OPW:0]  trial;
	logic          ge;

	always_comb begin
		acc_n = bsh_q[0] ? acc_q + ash_q : acc_q;
		trial = {rem_q, acc_q[OPW-1]};
		ge    = trial >= {1'b0, c_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			div_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				div_q  <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(OPW - 1)) begin
					cnt_q <= '0;
					if (div_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					div_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			ash_q <= PW'(a);
			bsh_q <= b;
			c_q   <= c;
		end else if (busy_q && !div_q) begin
			ash_q <= ash_q << 1;
			bsh_q <= bsh_q >> 1;
			if (cnt_q == CW'(OPW - 1)) begin
				// product done: high half seeds the remainder, low half shifts quotient in
				rem_q <= acc_n[PW-1:OPW];
				acc_q <= acc_n;
			end else begin
				acc_q <= acc_n;
			end
		end else if (busy_q) begin
			rem_q <= ge ? OPW'(trial - {1'b0, c_q}) : trial[OPW-1:0];
			acc_q[OPW-1:0] <= {acc_q[OPW-2:0], ge};
		end
	end

	assign q         = acc_q[OPW-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* hw/rtl/vfsc_speed.sv */
// Bit-serial speed: squares of both magnitudes, then a one-bit-per-cycle square root.
module vfsc_speed #(
	parameter int W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [W-1:0]         mx,
	input  logic [W-1:0]         my,
	output logic [W-1:0]         speed,
	output vfsc_pkg::unit_stat_t stat
);

	localparam int SW = W + 1;
	localparam int RW = 2 * SW;
	localparam int RM = SW + 2;
	localparam int CW = $clog2(SW + 1);

	typedef enum logic [2:0] {
		PH_SQX  = 3'b001,
		PH_SQY  = 3'b010,
		PH_ROOT = 3'b100
	} phase_t;

	phase_t        ph_q;
	logic          busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] acc_q, ash_q;
	logic [W-1:0]  bsh_q, my_q;
	logic [RM-1:0] rem_q;
	logic [SW-1:0] root_q;

	logic [RW-1:0] acc_n;
	logic [RM-1:0] rem_sh, trial;
	logic          ge;

	always_comb begin
		acc_n  = bsh_q[0] ? acc_q + ash_q : acc_q;
		rem_sh = {rem_q[RM-3:0], acc_q[RW-1:RW-2]};
		trial  = {root_q, 2'b01};
		ge     = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= PH_SQX;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ph_q   <= PH_SQX;
				cnt_q  <= '0;
			end else if (busy_q) begin
				case (ph_q)
					PH_SQX, PH_SQY: begin
						if (cnt_q == CW'(W - 1)) begin
							cnt_q <= '0;
							ph_q  <= (ph_q == PH_SQX) ? PH_SQY : PH_ROOT;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
					PH_ROOT: begin
						if (cnt_q == CW'(SW - 1)) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
						cnt_q <= cnt_q + CW'(1);
					end
					default: ph_q <= PH_SQX;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			ash_q  <= RW'(mx);
			bsh_q  <= mx;
			my_q   <= my;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			case (ph_q)
				PH_SQX: begin
					acc_q <= acc_n;
					if (cnt_q == CW'(W - 1)) begin
						ash_q <= RW'(my_q);
						bsh_q <= my_q;
					end else begin
						ash_q <= ash_q << 1;
						bsh_q <= bsh_q >> 1;
					end
				end
				PH_SQY: begin
					acc_q <= acc_n;
					ash_q <= ash_q << 1;
					bsh_q <= bsh_q >> 1;
				end
				PH_ROOT: begin
					// consume two radicand bits, decide one root bit
					acc_q  <= acc_q << 2;
					rem_q  <= ge ? rem_sh - trial : rem_sh;
					root_q <= {root_q[SW-2:0], ge};
				end
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign speed     = root_q[W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
